// ===== rtl/page_stream_prefetch_buffer_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the page stream prefetch buffer
// Concurrent checks clocked on clock and held off while reset is high.
// ----------------------------------------------------------------------------
`ifndef PAGE_STREAM_PREFETCH_BUFFER_CORE_DEFINES_SVH
`define PAGE_STREAM_PREFETCH_BUFFER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// A property that must hold at every clock edge outside reset.
`define PSB_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// An implication checked in the same cycle.
`define PSB_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// An implication whose consequent is checked in the cycle after the antecedent.
`define PSB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define PSB_ASSERT(lbl, prop, msg)
`define PSB_ASSERT_IMP(lbl, ante, cons, msg)
`define PSB_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/psb_pkg.sv =====
// ----------------------------------------------------------------------------
// psb_pkg
// Shared widths, microcode word layout and codes of the prefetch buffer.
// ----------------------------------------------------------------------------
package psb_pkg;

   localparam int PAGE_W           = 52;
   localparam int ADDR_W           = 64;
   localparam int REQ_TDATA_W      = 56;
   localparam int CFG_W            = 5;
   localparam int OFFSET_W         = 7;
   localparam int CAND_W           = 6;
   localparam int OFFSETS_PER_PAGE = 64;
   localparam int MAX_DEGREE       = 16;
   localparam int CSR_ADDR_W       = 3;
   localparam int CSR_DATA_W       = 32;

   // Register indexes, taken from byte address bit 2.
   localparam logic REG_BUFFER_LIMIT = 1'b0;
   localparam logic REG_DEGREE       = 1'b1;

   localparam logic [CFG_W-1:0] BUFFER_LIMIT_RESET = 5'd16;
   localparam logic [CFG_W-1:0] DEGREE_RESET       = 5'd4;

   // Sequencer step addresses.
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_IDLE       = 3'd0;
   localparam logic [STEP_W-1:0] STEP_SCAN_ISSUE = 3'd1;
   localparam logic [STEP_W-1:0] STEP_SCAN_CMP   = 3'd2;
   localparam logic [STEP_W-1:0] STEP_ALLOC      = 3'd3;
   localparam logic [STEP_W-1:0] STEP_SETUP      = 3'd4;
   localparam logic [STEP_W-1:0] STEP_EMIT       = 3'd5;

   // Jump conditions.
   localparam int COND_W = 3;
   localparam logic [COND_W-1:0] COND_ALWAYS    = 3'd0;
   localparam logic [COND_W-1:0] COND_ACCEPT    = 3'd1;
   localparam logic [COND_W-1:0] COND_SCAN_END  = 3'd2;
   localparam logic [COND_W-1:0] COND_TAG_HIT   = 3'd3;
   localparam logic [COND_W-1:0] COND_NO_EMIT   = 3'd4;
   localparam logic [COND_W-1:0] COND_EMIT_DONE = 3'd5;

   typedef struct packed {
      logic in_ready;
      logic scan_rd;
      logic scan_cmp;
      logic alloc;
      logic setup;
      logic emit;
   } psb_ctl_type;

   typedef struct packed {
      logic accept;
      logic scan_end;
      logic tag_hit;
      logic no_emit;
      logic emit_done;
   } psb_flags_type;

   typedef struct packed {
      psb_ctl_type             ctl;
      logic [COND_W-1:0]       cond;
      logic [STEP_W-1:0]       jump;
      logic [STEP_W-1:0]       next;
   } psb_uword_type;

endpackage

// ===== rtl/psb_csr.sv =====
// ----------------------------------------------------------------------------
// psb_csr
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module psb_csr
   import psb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [CFG_W-1:0]      buffer_limit,
   output logic [CFG_W-1:0]      degree
);

   logic [CFG_W-1:0] buffer_limit_ff, buffer_limit_in;
   logic [CFG_W-1:0] degree_ff, degree_in;
   logic             wr_fire;
   logic             reg_sel;

   assign csr_pready = 1'b1;
   assign wr_fire    = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      buffer_limit_in = buffer_limit_ff;
      degree_in       = degree_ff;
      if (wr_fire) begin
         unique case (reg_sel)
            REG_BUFFER_LIMIT: buffer_limit_in = csr_pwdata[CFG_W-1:0];
            REG_DEGREE:       degree_in       = csr_pwdata[CFG_W-1:0];
            default:          buffer_limit_in = buffer_limit_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_BUFFER_LIMIT: csr_prdata = CSR_DATA_W'(buffer_limit_ff);
         REG_DEGREE:       csr_prdata = CSR_DATA_W'(degree_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_limit_ff <= BUFFER_LIMIT_RESET;
         degree_ff       <= DEGREE_RESET;
      end else begin
         buffer_limit_ff <= buffer_limit_in;
         degree_ff       <= degree_in;
      end
   end

   assign buffer_limit = buffer_limit_ff;
   assign degree       = degree_ff;

endmodule

// ===== rtl/psb_entry_ram.sv =====
// ----------------------------------------------------------------------------
// psb_entry_ram
// Page tag and next offset store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module psb_entry_ram #(
   parameter int DEPTH  = 16,
   parameter int IDX_W  = 4,
   parameter int DATA_W = 59
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/psb_sequencer.sv =====
// ----------------------------------------------------------------------------
// psb_sequencer
// Microcode store and step counter; each step issues one control word.
// ----------------------------------------------------------------------------
module psb_sequencer
   import psb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  psb_flags_type flags,
   output psb_ctl_type   ctl
);

   logic [STEP_W-1:0] step_ff, step_in;
   psb_uword_type     uword;
   logic              take_jump;

   function automatic psb_uword_type ucode(input logic [STEP_W-1:0] step);
      psb_uword_type uw;
      uw = '0;
      unique case (step)
         STEP_IDLE: begin
            uw.ctl.in_ready = 1'b1;
            uw.cond = COND_ACCEPT;
            uw.jump = STEP_SCAN_ISSUE;
            uw.next = STEP_IDLE;
         end
         STEP_SCAN_ISSUE: begin
            uw.ctl.scan_rd = 1'b1;
            uw.cond = COND_SCAN_END;
            uw.jump = STEP_ALLOC;
            uw.next = STEP_SCAN_CMP;
         end
         STEP_SCAN_CMP: begin
            uw.ctl.scan_cmp = 1'b1;
            uw.cond = COND_TAG_HIT;
            uw.jump = STEP_SETUP;
            uw.next = STEP_SCAN_ISSUE;
         end
         STEP_ALLOC: begin
            uw.ctl.alloc = 1'b1;
            uw.cond = COND_ALWAYS;
            uw.jump = STEP_SETUP;
            uw.next = STEP_SETUP;
         end
         STEP_SETUP: begin
            uw.ctl.setup = 1'b1;
            uw.cond = COND_NO_EMIT;
            uw.jump = STEP_IDLE;
            uw.next = STEP_EMIT;
         end
         STEP_EMIT: begin
            uw.ctl.emit = 1'b1;
            uw.cond = COND_EMIT_DONE;
            uw.jump = STEP_IDLE;
            uw.next = STEP_EMIT;
         end
         default: begin
            uw.cond = COND_ALWAYS;
            uw.jump = STEP_IDLE;
            uw.next = STEP_IDLE;
         end
      endcase
      return uw;
   endfunction

   assign uword = ucode(step_ff);
   assign ctl   = uword.ctl;

   always_comb begin
      case (uword.cond)
         COND_ALWAYS:    take_jump = 1'b1;
         COND_ACCEPT:    take_jump = flags.accept;
         COND_SCAN_END:  take_jump = flags.scan_end;
         COND_TAG_HIT:   take_jump = flags.tag_hit;
         COND_NO_EMIT:   take_jump = flags.no_emit;
         COND_EMIT_DONE: take_jump = flags.emit_done;
         default:        take_jump = 1'b1;
      endcase
   end

   assign step_in = take_jump ? uword.jump : uword.next;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// ===== rtl/page_stream_prefetch_buffer_core.sv =====
// ----------------------------------------------------------------------------
// page_stream_prefetch_buffer_core
// Next-line stream prefetcher that tracks pages in a FIFO buffer.
// ----------------------------------------------------------------------------
// Each request transaction carries a page number. The page is looked up in a
// FIFO buffer of recently seen pages, oldest first, one entry at a time
// through the entry RAM's single registered read port (an issue step and a
// compare step per entry). On a miss the page is appended with a next offset
// of zero, evicting the oldest page when the buffer already holds the clamped
// buffer_limit pages. From the stored offset the block then emits up to degree
// consecutive block addresses of the page, one response transaction per cycle
// while the sink is ready, with tlast on the final one; the last offset is
// stored back at setup, before the run. No request is accepted until the
// previous trigger is through; the tag search reads the entries up to the hit,
// or every live entry on a miss. A trigger that emits nothing produces no
// response transaction at all. The final response may still wait in the
// output register while the next request is accepted. Configuration is to be
// written through the APB-style port only while the block is idle, which the
// block does not enforce; no clearing pass runs after reset.
// ----------------------------------------------------------------------------
`include "page_stream_prefetch_buffer_core_defines.svh"

module page_stream_prefetch_buffer_core
   import psb_pkg::*;
#(
   parameter int BUFFER_ENTRIES = 16,
   parameter int PAGE_SHIFT     = 12,
   parameter int BLOCK_SHIFT    = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request stream: tdata = page_number[51:0], zero padding[55:52].
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // Response stream: tdata = prefetch_address[63:0]; tlast = last_of_run.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [ADDR_W-1:0]      rsp_tdata,
   output logic                   rsp_tlast,
   // Configuration port.
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   localparam int IDX_W   = (BUFFER_ENTRIES > 1) ? $clog2(BUFFER_ENTRIES) : 1;
   localparam int CNT_W   = $clog2(BUFFER_ENTRIES + 1);
   localparam int SUM_W   = IDX_W + 1;
   localparam int LIM_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int ENTRY_W = PAGE_W + OFFSET_W;

   // Ring index arithmetic: the operands never exceed the depth and their sum
   // stays below twice it, so one compare and subtract folds it back into range.
   function automatic logic [IDX_W-1:0] ring_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
      logic [SUM_W-1:0] sum;
      sum = a + b;
      if (sum >= SUM_W'(BUFFER_ENTRIES)) begin
         sum = sum - SUM_W'(BUFFER_ENTRIES);
      end
      return sum[IDX_W-1:0];
   endfunction

   // Configuration.
   logic [CFG_W-1:0] buffer_limit;
   logic [CFG_W-1:0] degree;

   psb_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .buffer_limit (buffer_limit),
      .degree       (degree)
   );

   // Sequencer.
   psb_ctl_type   ctl;
   psb_flags_type flags;

   psb_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctl   (ctl)
   );

   // Datapath registers.
   logic [PAGE_W-1:0]   page_ff, page_in;
   logic [CNT_W-1:0]    pos_ff, pos_in;
   logic [IDX_W-1:0]    slot_ff, slot_in;
   logic [OFFSET_W-1:0] last_ff, last_in;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CAND_W-1:0]   cand_ff, cand_in;
   logic [CFG_W-1:0]    remain_ff, remain_in;
   logic                out_valid_ff, out_valid_in;
   logic [ADDR_W-1:0]   out_data_ff, out_data_in;
   logic                out_last_ff, out_last_in;

   // Entry RAM.
   logic                rd_en;
   logic [IDX_W-1:0]    scan_slot;
   logic [ENTRY_W-1:0]  rd_data;
   logic [PAGE_W-1:0]   rd_tag;
   logic [OFFSET_W-1:0] rd_off;
   logic                wr_en;
   logic [ENTRY_W-1:0]  wr_data;

   // Combinational helpers.
   logic                req_accept;
   logic                emit_fire;
   logic [LIM_W-1:0]    limit_eff;
   logic [CFG_W-1:0]    degree_eff;
   logic [OFFSET_W-1:0] degree_ext;
   logic [OFFSET_W-1:0] room;
   logic [OFFSET_W-1:0] run_len;
   logic [OFFSET_W-1:0] end_sum;
   logic [OFFSET_W-1:0] store_off;
   logic [ADDR_W-1:0]   next_addr;

   assign req_tready = ctl.in_ready;
   assign req_accept = req_tvalid && req_tready;
   assign emit_fire  = ctl.emit && (!out_valid_ff || rsp_tready);

   // A limit of zero acts as one; a limit beyond the RAM depth acts as the
   // depth.
   always_comb begin
      if (buffer_limit == '0) begin
         limit_eff = LIM_W'(1);
      end else if (LIM_W'(buffer_limit) > LIM_W'(BUFFER_ENTRIES)) begin
         limit_eff = LIM_W'(BUFFER_ENTRIES);
      end else begin
         limit_eff = LIM_W'(buffer_limit);
      end
   end

   assign degree_eff = (degree > CFG_W'(MAX_DEGREE)) ? CFG_W'(MAX_DEGREE) : degree;
   assign degree_ext = OFFSET_W'(degree_eff);

   // Offsets run from the stored one plus one up to the last offset of the
   // page. The stored value becomes the last offset emitted, or the page end
   // once the run hits it, and a zero degree stores zero.
   assign room    = (last_ff >= OFFSET_W'(OFFSETS_PER_PAGE - 1)) ? '0 :
                    OFFSET_W'(OFFSETS_PER_PAGE - 1) - last_ff;
   assign run_len = (degree_ext < room) ? degree_ext : room;
   assign end_sum = last_ff + degree_ext;

   always_comb begin
      if (degree_eff == '0) begin
         store_off = '0;
      end else if (end_sum > OFFSET_W'(OFFSETS_PER_PAGE)) begin
         store_off = OFFSET_W'(OFFSETS_PER_PAGE);
      end else begin
         store_off = end_sum;
      end
   end

   assign next_addr = (ADDR_W'(page_ff) << PAGE_SHIFT) + (ADDR_W'(cand_ff) << BLOCK_SHIFT);

   assign scan_slot = ring_add(SUM_W'(head_ff), SUM_W'(pos_ff));
   assign rd_en     = ctl.scan_rd;
   assign rd_tag    = rd_data[ENTRY_W-1:OFFSET_W];
   assign rd_off    = rd_data[OFFSET_W-1:0];

   // The whole entry is rewritten at setup, for hits and for new pages alike.
   assign wr_en   = ctl.setup;
   assign wr_data = {page_ff, store_off};

   psb_entry_ram #(
      .DEPTH  (BUFFER_ENTRIES),
      .IDX_W  (IDX_W),
      .DATA_W (ENTRY_W)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (scan_slot),
      .rd_data (rd_data)
   );

   // Condition flags back to the sequencer.
   assign flags.accept    = req_accept;
   assign flags.scan_end  = (pos_ff == count_ff);
   assign flags.tag_hit   = (rd_tag == page_ff);
   assign flags.no_emit   = (run_len == '0);
   assign flags.emit_done = emit_fire && (remain_ff == CFG_W'(1));

   always_comb begin
      page_in      = page_ff;
      pos_in       = pos_ff;
      slot_in      = slot_ff;
      last_in      = last_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      cand_in      = cand_ff;
      remain_in    = remain_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;

      if (req_accept) begin
         page_in = req_tdata[PAGE_W-1:0];
         pos_in  = '0;
      end

      // The slot being read is kept so that a hit knows where to write back.
      if (ctl.scan_rd) begin
         slot_in = scan_slot;
      end

      if (ctl.scan_cmp) begin
         if (flags.tag_hit) begin
            last_in = rd_off;
         end else begin
            pos_in = pos_ff + CNT_W'(1);
         end
      end

      // A new page takes the oldest slot when the buffer is at its limit,
      // otherwise the slot after the newest one.
      if (ctl.alloc) begin
         last_in = '0;
         if (LIM_W'(count_ff) >= limit_eff) begin
            slot_in = head_ff;
            head_in = ring_add(SUM_W'(head_ff), SUM_W'(1));
         end else begin
            slot_in  = ring_add(SUM_W'(head_ff), SUM_W'(count_ff));
            count_in = count_ff + CNT_W'(1);
         end
      end

      if (ctl.setup) begin
         cand_in   = last_ff[CAND_W-1:0] + CAND_W'(1);
         remain_in = CFG_W'(run_len);
      end

      if (emit_fire) begin
         out_valid_in = 1'b1;
         out_data_in  = next_addr;
         out_last_in  = (remain_ff == CFG_W'(1));
         cand_in      = cand_ff + CAND_W'(1);
         remain_in    = remain_ff - CFG_W'(1);
      end else if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff     <= page_in;
      pos_ff      <= pos_in;
      slot_ff     <= slot_in;
      last_ff     <= last_in;
      cand_ff     <= cand_in;
      remain_ff   <= remain_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   `PSB_ASSERT(a_count_in_range, count_ff <= CNT_W'(BUFFER_ENTRIES), "entry count beyond depth")
   `PSB_ASSERT_IMP(a_emit_has_work, ctl.emit, remain_ff != '0, "emit step with nothing left")
   `PSB_ASSERT_IMP(a_slot_in_range, ctl.setup, SUM_W'(slot_ff) < SUM_W'(BUFFER_ENTRIES), "slot index out of ring")
   `PSB_ASSERT_NEXT(a_one_at_a_time, req_accept, !req_tready, "request taken while busy")

endmodule
